// ===== hw/rtl/bcfd_pkg.sv =====
`default_nettype none

package bcfd_pkg;

  localparam int unsigned CELL_SLOTS = 192;
  localparam int unsigned CELL_AW    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;

  localparam logic [28:0] ID_MAIN   = 29'h0C50FF50;
  localparam logic [28:0] ID_VOLT   = 29'h0C50FF51;
  localparam logic [28:0] ID_TEMP   = 29'h0C50FF52;
  localparam logic [28:0] ID_SWITCH = 29'h0C50FF33;
  localparam logic [28:0] ID_ALARM  = 29'h0C50FF34;
  localparam logic [28:0] ID_FAULT  = 29'h0C50FF35;
  localparam logic [28:0] ID_CELLV  = 29'h0C50FF55;
  localparam logic [28:0] ID_BAL    = 29'h0C50FF3C;

  localparam logic [7:0]  MUX_LOW   = 8'h43;
  localparam logic [7:0]  MUX_HIGH  = 8'h83;
  localparam logic [15:0] MAIN_BIT  = 16'h0002;

  localparam logic [3:0]  LEN_FULL  = 4'd8;
  localparam logic [3:0]  LEN_WORDS = 4'd4;
  localparam logic [13:0] PCT_MAX   = 14'd10000;

  localparam logic [1:0]  MODE_STANDBY = 2'd0;
  localparam logic [1:0]  MODE_ACTIVE  = 2'd1;
  localparam logic [1:0]  MODE_FAULT   = 2'd2;

  typedef logic [7:0][7:0] byte_vec_t;

  typedef struct packed {
    logic        volt_we;
    logic        bal_we;
    logic [7:0]  idx;
    logic [15:0] volt;
    logic        bal;
  } cell_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
  } cell_rd_t;

  typedef struct packed {
    logic [15:0] pack_voltage;
    logic [13:0] soc;
    logic [13:0] soh;
    logic [15:0] min_cell;
    logic [15:0] max_cell;
    logic [19:0] min_temp;
    logic [19:0] max_temp;
    logic [1:0]  bms_state;
    logic [2:0]  flags;
  } status_t;

  function automatic logic [15:0] word_at(byte_vec_t b, logic [2:0] pos);
    logic [2:0] hi;
    hi = pos + 3'd1;
    return {b[hi], b[pos]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bms_can_frame_decoder_top.sv =====
`default_nettype none

// Decodes battery-management CAN frames into a pack status summary and keeps a
// per-cell voltage and balancing store; each beat in gives one result beat out.
// Reads, short frames and frames other than cell-voltage or balancing go straight
// to the result stage; a cell-voltage frame first steps through three cells and a
// balancing frame six, through the single write port of the cell store (one cell
// per cycle). The next beat is taken while a result still waits on the output
// register. After reset the cell store clears all 192 entries, one entry per
// cycle, with the input stalled until it is done.
module bms_can_frame_decoder_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         cmd_i,
  input  wire  [28:0] frame_id_i,
  input  wire  [3:0]  frame_len_i,
  input  wire  [7:0]  byte0_i,
  input  wire  [7:0]  byte1_i,
  input  wire  [7:0]  byte2_i,
  input  wire  [7:0]  byte3_i,
  input  wire  [7:0]  byte4_i,
  input  wire  [7:0]  byte5_i,
  input  wire  [7:0]  byte6_i,
  input  wire  [7:0]  byte7_i,
  input  wire  [7:0]  query_cell_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] pack_voltage_dv_o,
  output logic [13:0] soc_pptt_o,
  output logic [13:0] health_pptt_o,
  output logic [15:0] min_cell_mv_o,
  output logic [15:0] max_cell_mv_o,
  output logic [19:0] min_temp_dc_o,
  output logic [19:0] max_temp_dc_o,
  output logic [7:0]  cell_count_o,
  output logic [1:0]  bms_state_o,
  output logic [3:0]  status_flags_o,
  output logic [15:0] cell_voltage_mv_o,
  output logic        cell_balancing_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELLW,
    ST_BALW,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic [2:0] step_q;
  bcfd_pkg::byte_vec_t bytes_q;
  logic       alive_q;
  logic       is_read_q;
  logic [7:0] hcc_q;
  logic       out_valid_q;

  bcfd_pkg::byte_vec_t in_bytes;
  bcfd_pkg::cell_wr_t  wr;
  bcfd_pkg::cell_rd_t  rd;
  bcfd_pkg::status_t   status;
  logic        accept;
  logic        full_len;
  logic [7:0]  cidx;
  logic        cidx_in_rng;
  logic [15:0] mv;
  logic [2:0]  bal_pos;
  logic [15:0] rd_volt;
  logic        rd_bal;
  logic        store_busy;
  logic        out_free;
  logic        out_load;

  assign in_bytes = {byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i, byte0_i};
  assign accept   = in_valid_i && (state_q == ST_IDLE) && !store_busy;
  assign in_stall_o = (state_q != ST_IDLE) || store_busy;
  assign full_len = frame_len_i >= bcfd_pkg::LEN_FULL;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_FINISH) && out_free;

  assign cidx        = bytes_q[1] + {5'd0, step_q};
  assign cidx_in_rng = {1'b0, cidx} < 9'(bcfd_pkg::CELL_SLOTS);
  assign mv          = bcfd_pkg::word_at(bytes_q, {step_q[1:0], 1'b0} + 3'd2);
  assign bal_pos     = step_q + 3'd2;

  always_comb begin
    wr.volt_we = (state_q == ST_CELLW) && cidx_in_rng && (mv != 16'd0);
    wr.bal_we  = (state_q == ST_BALW) && cidx_in_rng;
    wr.idx     = cidx;
    wr.volt    = mv;
    wr.bal     = bytes_q[bal_pos] != 8'd0;
    rd.en      = accept && cmd_i;
    rd.idx     = query_cell_i;
  end

  bcfd_cell_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_volt_o (rd_volt),
    .rd_bal_o  (rd_bal),
    .busy_o    (store_busy)
  );

  bcfd_status u_status (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (accept && !cmd_i),
    .frame_id_i  (frame_id_i),
    .frame_len_i (frame_len_i),
    .bytes_i     (in_bytes),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      step_q            <= '0;
      bytes_q           <= '0;
      alive_q           <= 1'b0;
      is_read_q         <= 1'b0;
      hcc_q             <= '0;
      out_valid_q       <= 1'b0;
      pack_voltage_dv_o <= '0;
      soc_pptt_o        <= '0;
      health_pptt_o     <= '0;
      min_cell_mv_o     <= '0;
      max_cell_mv_o     <= '0;
      min_temp_dc_o     <= '0;
      max_temp_dc_o     <= '0;
      cell_count_o      <= '0;
      bms_state_o       <= '0;
      status_flags_o    <= '0;
      cell_voltage_mv_o <= '0;
      cell_balancing_o  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            bytes_q   <= in_bytes;
            step_q    <= '0;
            is_read_q <= cmd_i;
            alive_q   <= !cmd_i && full_len && (frame_id_i == bcfd_pkg::ID_MAIN);
            if (!cmd_i && full_len && frame_id_i == bcfd_pkg::ID_CELLV) begin
              state_q <= ST_CELLW;
            end else if (!cmd_i && full_len && frame_id_i == bcfd_pkg::ID_BAL) begin
              state_q <= ST_BALW;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_CELLW: begin
          if (wr.volt_we && ({1'b0, cidx} + 9'd1 > {1'b0, hcc_q})) begin
            hcc_q <= cidx + 8'd1;
          end
          step_q <= step_q + 3'd1;
          if (step_q == 3'd2) begin
            state_q <= ST_FINISH;
          end
        end
        ST_BALW: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            pack_voltage_dv_o <= status.pack_voltage;
            soc_pptt_o        <= status.soc;
            health_pptt_o     <= status.soh;
            min_cell_mv_o     <= status.min_cell;
            max_cell_mv_o     <= status.max_cell;
            min_temp_dc_o     <= status.min_temp;
            max_temp_dc_o     <= status.max_temp;
            cell_count_o      <= hcc_q;
            bms_state_o       <= status.bms_state;
            status_flags_o    <= {alive_q, status.flags};
            cell_voltage_mv_o <= is_read_q ? rd_volt : 16'd0;
            cell_balancing_o  <= is_read_q && rd_bal;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bcfd_cell_store.sv =====
`default_nettype none

module bcfd_cell_store (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bcfd_pkg::cell_wr_t  wr_i,
  input  bcfd_pkg::cell_rd_t  rd_i,
  output logic [15:0]         rd_volt_o,
  output logic                rd_bal_o,
  output logic                busy_o
);

  logic [15:0] volt_mem [bcfd_pkg::CELL_SLOTS];
  logic        bal_mem  [bcfd_pkg::CELL_SLOTS];

  logic [bcfd_pkg::CELL_AW-1:0] clr_addr_q;
  logic                         clr_busy_q;

  logic [bcfd_pkg::CELL_AW-1:0] wr_addr;
  logic [bcfd_pkg::CELL_AW-1:0] rd_addr;
  logic        volt_we;
  logic        bal_we;
  logic [15:0] volt_wd;
  logic        bal_wd;
  logic        rd_in_rng;
  logic [15:0] volt_rd_q;
  logic        bal_rd_q;
  logic        rd_ok_q;

  // clearing pass after reset owns the write port
  assign volt_we   = clr_busy_q || wr_i.volt_we;
  assign bal_we    = clr_busy_q || wr_i.bal_we;
  assign wr_addr   = clr_busy_q ? clr_addr_q : bcfd_pkg::CELL_AW'(wr_i.idx);
  assign volt_wd   = clr_busy_q ? 16'd0 : wr_i.volt;
  assign bal_wd    = !clr_busy_q && wr_i.bal;
  assign rd_addr   = bcfd_pkg::CELL_AW'(rd_i.idx);
  assign rd_in_rng = {1'b0, rd_i.idx} < 9'(bcfd_pkg::CELL_SLOTS);

  always_ff @(posedge clk_i) begin
    if (volt_we) begin
      volt_mem[wr_addr] <= volt_wd;
    end
    if (bal_we) begin
      bal_mem[wr_addr] <= bal_wd;
    end
    if (rd_i.en) begin
      volt_rd_q <= volt_mem[rd_addr];
      bal_rd_q  <= bal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
      rd_ok_q    <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == bcfd_pkg::CELL_AW'(bcfd_pkg::CELL_SLOTS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (rd_i.en) begin
        rd_ok_q <= rd_in_rng;
      end
    end
  end

  assign rd_volt_o = rd_ok_q ? volt_rd_q : 16'd0;
  assign rd_bal_o  = rd_ok_q && bal_rd_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bcfd_status.sv =====
`default_nettype none

module bcfd_status (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  upd_i,
  input  wire  [28:0]          frame_id_i,
  input  wire  [3:0]           frame_len_i,
  input  bcfd_pkg::byte_vec_t  bytes_i,
  output bcfd_pkg::status_t    status_o
);

  logic [15:0] pack_q, pack_d;
  logic [15:0] soc_q, soc_d;
  logic [15:0] soh_q, soh_d;
  logic [15:0] lcell_q, lcell_d;
  logic [15:0] hcell_q, hcell_d;
  logic [15:0] ltemp_q, ltemp_d;
  logic [15:0] htemp_q, htemp_d;
  logic        contactor_q, contactor_d;
  logic [3:0][15:0] alarm_q, alarm_d;
  logic [3:0][15:0] fault_q, fault_d;

  logic        full_len;
  logic [3:0]  wcnt_raw;
  logic [1:0]  wcnt;
  logic [15:0] w2, w4;
  logic [2:0][15:0] words;
  logic [2:0][7:0]  subs;
  logic [3:0][15:0] words_upd_alarm, words_upd_fault;
  logic        any_alarm, any_fault;
  logic [19:0] soc_x10, soh_x10;
  logic signed [19:0] ltemp_ext, htemp_ext;

  assign full_len = frame_len_i >= bcfd_pkg::LEN_FULL;
  assign w2       = bcfd_pkg::word_at(bytes_i, 3'd2);
  assign w4       = bcfd_pkg::word_at(bytes_i, 3'd4);
  assign wcnt_raw = (frame_len_i - 4'd2) >> 1;
  assign wcnt     = (wcnt_raw > 4'd3) ? 2'd3 : wcnt_raw[1:0];

  always_comb begin
    words_upd_alarm = alarm_q;
    words_upd_fault = fault_q;
    for (int i = 0; i < 3; i++) begin
      words[i] = bcfd_pkg::word_at(bytes_i, 3'(2 + 2 * i));
      subs[i]  = bytes_i[1] + 8'(i);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (2'(i) < wcnt && subs[i] == 8'(k)) begin
          words_upd_alarm[k] = words[i];
          words_upd_fault[k] = words[i];
        end
      end
    end
  end

  always_comb begin
    pack_d      = pack_q;
    soc_d       = soc_q;
    soh_d       = soh_q;
    lcell_d     = lcell_q;
    hcell_d     = hcell_q;
    ltemp_d     = ltemp_q;
    htemp_d     = htemp_q;
    contactor_d = contactor_q;
    alarm_d     = alarm_q;
    fault_d     = fault_q;
    if (upd_i) begin
      if (frame_id_i == bcfd_pkg::ID_ALARM) begin
        if (frame_len_i >= bcfd_pkg::LEN_WORDS) begin
          alarm_d = words_upd_alarm;
        end
      end else if (frame_id_i == bcfd_pkg::ID_FAULT) begin
        if (frame_len_i >= bcfd_pkg::LEN_WORDS) begin
          fault_d = words_upd_fault;
        end
      end else if (full_len) begin
        unique case (frame_id_i)
          bcfd_pkg::ID_MAIN: begin
            if (bytes_i[0] == bcfd_pkg::MUX_LOW) begin
              pack_d = w2;
            end else if (bytes_i[0] == bcfd_pkg::MUX_HIGH) begin
              soc_d = w2;
              soh_d = w4;
            end
          end
          bcfd_pkg::ID_VOLT: begin
            if (bytes_i[0] == bcfd_pkg::MUX_LOW) begin
              lcell_d = w4;
            end else if (bytes_i[0] == bcfd_pkg::MUX_HIGH) begin
              hcell_d = w4;
            end
          end
          bcfd_pkg::ID_TEMP: begin
            if (bytes_i[0] == bcfd_pkg::MUX_LOW) begin
              ltemp_d = w4;
            end else if (bytes_i[0] == bcfd_pkg::MUX_HIGH) begin
              htemp_d = w4;
            end
          end
          bcfd_pkg::ID_SWITCH: begin
            contactor_d = (w2 & bcfd_pkg::MAIN_BIT) != 16'd0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      soc_q       <= '0;
      soh_q       <= '0;
      lcell_q     <= '0;
      hcell_q     <= '0;
      ltemp_q     <= '0;
      htemp_q     <= '0;
      contactor_q <= 1'b0;
      alarm_q     <= '0;
      fault_q     <= '0;
    end else begin
      pack_q      <= pack_d;
      soc_q       <= soc_d;
      soh_q       <= soh_d;
      lcell_q     <= lcell_d;
      hcell_q     <= hcell_d;
      ltemp_q     <= ltemp_d;
      htemp_q     <= htemp_d;
      contactor_q <= contactor_d;
      alarm_q     <= alarm_d;
      fault_q     <= fault_d;
    end
  end

  assign any_alarm = |alarm_q;
  assign any_fault = |fault_q;
  assign soc_x10   = 20'(soc_q) * 20'd10;
  assign soh_x10   = 20'(soh_q) * 20'd10;
  assign ltemp_ext = 20'(signed'(ltemp_q));
  assign htemp_ext = 20'(signed'(htemp_q));

  always_comb begin
    status_o.pack_voltage = pack_q;
    status_o.soc      = (soc_x10 > 20'(bcfd_pkg::PCT_MAX)) ? bcfd_pkg::PCT_MAX : soc_x10[13:0];
    status_o.soh      = (soh_x10 > 20'(bcfd_pkg::PCT_MAX)) ? bcfd_pkg::PCT_MAX : soh_x10[13:0];
    status_o.min_cell = lcell_q;
    status_o.max_cell = hcell_q;
    status_o.min_temp = 20'(ltemp_ext * 20'sd10);
    status_o.max_temp = 20'(htemp_ext * 20'sd10);
    if (any_fault) begin
      status_o.bms_state = bcfd_pkg::MODE_FAULT;
    end else if (contactor_q) begin
      status_o.bms_state = bcfd_pkg::MODE_ACTIVE;
    end else begin
      status_o.bms_state = bcfd_pkg::MODE_STANDBY;
    end
    status_o.flags = {any_fault, any_alarm, contactor_q && !any_fault};
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic                cmd;
    logic [28:0]         id;
    logic [3:0]          len;
    bcfd_pkg::byte_vec_t data;
    logic [7:0]          query;
  } can_item_t;

  typedef struct packed {
    logic [15:0] pack_v;
    logic [13:0] soc;
    logic [13:0] soh;
    logic [15:0] min_cell;
    logic [15:0] max_cell;
    logic [19:0] min_temp;
    logic [19:0] max_temp;
    logic [7:0]  cell_count;
    logic [1:0]  state;
    logic [3:0]  flags;
    logic [15:0] cell_v;
    logic        cell_bal;
  } bms_summary_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                in_valid;
  logic                in_stall;
  logic                cmd;
  logic [28:0]         frame_id;
  logic [3:0]          frame_len;
  bcfd_pkg::byte_vec_t frame_bytes;
  logic [7:0]          query_cell;
  logic                out_valid;
  logic                out_stall;
  logic [15:0]         pack_voltage_dv;
  logic [13:0]         soc_pptt;
  logic [13:0]         health_pptt;
  logic [15:0]         min_cell_mv;
  logic [15:0]         max_cell_mv;
  logic [19:0]         min_temp_dc;
  logic [19:0]         max_temp_dc;
  logic [7:0]          cell_count;
  logic [1:0]          bms_state;
  logic [3:0]          status_flags;
  logic [15:0]         cell_voltage_mv;
  logic                cell_balancing;

  bms_can_frame_decoder_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .frame_id_i       (frame_id),
    .frame_len_i      (frame_len),
    .byte0_i          (frame_bytes[0]),
    .byte1_i          (frame_bytes[1]),
    .byte2_i          (frame_bytes[2]),
    .byte3_i          (frame_bytes[3]),
    .byte4_i          (frame_bytes[4]),
    .byte5_i          (frame_bytes[5]),
    .byte6_i          (frame_bytes[6]),
    .byte7_i          (frame_bytes[7]),
    .query_cell_i     (query_cell),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pack_voltage_dv_o(pack_voltage_dv),
    .soc_pptt_o       (soc_pptt),
    .health_pptt_o    (health_pptt),
    .min_cell_mv_o    (min_cell_mv),
    .max_cell_mv_o    (max_cell_mv),
    .min_temp_dc_o    (min_temp_dc),
    .max_temp_dc_o    (max_temp_dc),
    .cell_count_o     (cell_count),
    .bms_state_o      (bms_state),
    .status_flags_o   (status_flags),
    .cell_voltage_mv_o(cell_voltage_mv),
    .cell_balancing_o (cell_balancing)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the pack state
  logic [15:0] pack_raw, soc_raw, soh_raw, lo_cell, hi_cell, lo_temp, hi_temp;
  logic        contactor_closed;
  logic [15:0] alarm_w [4];
  logic [15:0] fault_w [4];
  logic [15:0] cell_mv [bcfd_pkg::CELL_SLOTS];
  logic        bal_bit [bcfd_pkg::CELL_SLOTS];
  logic [7:0]  cells_seen;

  can_item_t    pending_items[$];
  bms_summary_t expected_status[$];
  can_item_t    next_item, taken;
  bms_summary_t want;

  logic in_fire;
  int   cycle_count, mismatches, results_checked;
  int   frames_sent, reads_sent, store_frames;
  int   burst_left, gap_left;
  stall_mode_e stall_mode;
  int   stall_phase_left, stall_run_left;
  logic stall_run_val;

  function automatic logic [15:0] le_word(bcfd_pkg::byte_vec_t d, int pos);
    return {d[pos+1], d[pos]};
  endfunction

  function automatic logic [13:0] pct_scaled(logic [15:0] raw);
    int unsigned v;
    v = raw * 10;
    return (v > bcfd_pkg::PCT_MAX) ? bcfd_pkg::PCT_MAX : v[13:0];
  endfunction

  function automatic logic [19:0] temp_scaled(logic [15:0] raw);
    int t;
    t = $signed(raw);
    t = t * 10;
    return t[19:0];
  endfunction

  task automatic decode_item(input can_item_t it, output bms_summary_t s);
    logic        alive, alarm, fault;
    int unsigned n, sub, c, i;
    logic [15:0] w;
    alive = 1'b0;
    s = '0;
    if (it.cmd) begin
      if (it.query < bcfd_pkg::CELL_SLOTS) begin
        s.cell_v   = cell_mv[it.query];
        s.cell_bal = bal_bit[it.query];
      end
    end else if (it.id == bcfd_pkg::ID_ALARM || it.id == bcfd_pkg::ID_FAULT) begin
      if (it.len >= bcfd_pkg::LEN_WORDS) begin
        n = (int'(it.len) - 2) / 2;
        if (n > 3) n = 3;
        for (i = 0; i < n; i++) begin
          sub = (it.data[1] + i) & 8'hFF;
          w = le_word(it.data, 2 + 2 * i);
          if (sub < 4) begin
            if (it.id == bcfd_pkg::ID_ALARM) alarm_w[sub] = w;
            else fault_w[sub] = w;
          end
        end
      end
    end else if (it.len >= bcfd_pkg::LEN_FULL) begin
      case (it.id)
        bcfd_pkg::ID_MAIN: begin
          alive = 1'b1;
          if (it.data[0] == bcfd_pkg::MUX_LOW) pack_raw = le_word(it.data, 2);
          else if (it.data[0] == bcfd_pkg::MUX_HIGH) begin
            soc_raw = le_word(it.data, 2);
            soh_raw = le_word(it.data, 4);
          end
        end
        bcfd_pkg::ID_VOLT: begin
          if (it.data[0] == bcfd_pkg::MUX_LOW) lo_cell = le_word(it.data, 4);
          else if (it.data[0] == bcfd_pkg::MUX_HIGH) hi_cell = le_word(it.data, 4);
        end
        bcfd_pkg::ID_TEMP: begin
          if (it.data[0] == bcfd_pkg::MUX_LOW) lo_temp = le_word(it.data, 4);
          else if (it.data[0] == bcfd_pkg::MUX_HIGH) hi_temp = le_word(it.data, 4);
        end
        bcfd_pkg::ID_SWITCH:
          contactor_closed = (le_word(it.data, 2) & bcfd_pkg::MAIN_BIT) != 0;
        bcfd_pkg::ID_CELLV: begin
          for (i = 0; i < 3; i++) begin
            c = (it.data[1] + i) & 8'hFF;
            w = le_word(it.data, 2 + 2 * i);
            if (c < bcfd_pkg::CELL_SLOTS && w != 0) begin
              cell_mv[c] = w;
              if (c + 1 > cells_seen) cells_seen = 8'(c + 1);
            end
          end
        end
        bcfd_pkg::ID_BAL: begin
          for (i = 0; i < 6; i++) begin
            c = (it.data[1] + i) & 8'hFF;
            if (c < bcfd_pkg::CELL_SLOTS) bal_bit[c] = (it.data[2 + i] != 0);
          end
        end
        default: ;
      endcase
    end
    alarm = |(alarm_w[0] | alarm_w[1] | alarm_w[2] | alarm_w[3]);
    fault = |(fault_w[0] | fault_w[1] | fault_w[2] | fault_w[3]);
    s.pack_v     = pack_raw;
    s.soc        = pct_scaled(soc_raw);
    s.soh        = pct_scaled(soh_raw);
    s.min_cell   = lo_cell;
    s.max_cell   = hi_cell;
    s.min_temp   = temp_scaled(lo_temp);
    s.max_temp   = temp_scaled(hi_temp);
    s.cell_count = cells_seen;
    s.state      = fault ? bcfd_pkg::MODE_FAULT
                 : (contactor_closed ? bcfd_pkg::MODE_ACTIVE : bcfd_pkg::MODE_STANDBY);
    s.flags      = {alive, fault, alarm, contactor_closed && !fault};
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  function automatic can_item_t mk_frame(logic [28:0] id, logic [3:0] len,
                                         logic [63:0] data);
    can_item_t it;
    it = '0;
    it.id = id;
    it.len = len;
    it.data = data;
    return it;
  endfunction

  function automatic can_item_t cell_read(logic [7:0] q);
    can_item_t it;
    it = '0;
    it.cmd = 1'b1;
    it.query = q;
    return it;
  endfunction

  function automatic can_item_t random_item();
    can_item_t   it;
    int unsigned pick, i;
    it.cmd   = 1'b0;
    it.id    = 29'($urandom);
    it.len   = 4'($urandom_range(0, 15));
    it.data  = {$urandom, $urandom};
    it.query = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.cmd = 1'b1;
      if ($urandom_range(0, 7) != 0)
        it.query = 8'($urandom_range(0, bcfd_pkg::CELL_SLOTS - 1));
    end else if (pick < 90) begin
      case ($urandom_range(0, 7))
        0: it.id = bcfd_pkg::ID_MAIN;
        1: it.id = bcfd_pkg::ID_VOLT;
        2: it.id = bcfd_pkg::ID_TEMP;
        3: it.id = bcfd_pkg::ID_SWITCH;
        4: it.id = bcfd_pkg::ID_ALARM;
        5: it.id = bcfd_pkg::ID_FAULT;
        6: it.id = bcfd_pkg::ID_CELLV;
        default: it.id = bcfd_pkg::ID_BAL;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 8) it.len = bcfd_pkg::LEN_FULL;
      else if (pick == 8) it.len = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) != 0)
        it.data[0] = $urandom_range(0, 1) ? bcfd_pkg::MUX_HIGH : bcfd_pkg::MUX_LOW;
      if (it.id == bcfd_pkg::ID_CELLV) begin
        if ($urandom_range(0, 7) != 0)
          it.data[1] = 8'($urandom_range(0, bcfd_pkg::CELL_SLOTS - 1));
        for (i = 0; i < 3; i++)
          if ($urandom_range(0, 4) == 0) {it.data[2*i+3], it.data[2*i+2]} = 16'h0;
      end else if (it.id == bcfd_pkg::ID_BAL) begin
        if ($urandom_range(0, 7) != 0)
          it.data[1] = 8'($urandom_range(0, bcfd_pkg::CELL_SLOTS - 1));
        for (i = 2; i < 8; i++)
          if ($urandom_range(0, 1)) it.data[i] = 8'h00;
      end else if (it.id == bcfd_pkg::ID_ALARM || it.id == bcfd_pkg::ID_FAULT) begin
        if ($urandom_range(0, 5) != 0) it.data[1] = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 1)) it.data[7:2] = '0;
        if ($urandom_range(0, 2) == 0) it.len = 4'($urandom_range(4, 7));
      end
    end else if ($urandom_range(0, 1)) begin
      // near miss on a known identifier
      it.id = bcfd_pkg::ID_CELLV ^ (29'h1 << $urandom_range(0, 28));
    end
    return it;
  endfunction

  // sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          cmd         <= next_item.cmd;
          frame_id    <= next_item.id;
          frame_len   <= next_item.len;
          frame_bytes <= next_item.data;
          query_cell  <= next_item.query;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes
  always @(negedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(20, 120);
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run_left == 0) begin
          stall_run_left = $urandom_range(1, 16);
          stall_run_val = !stall_run_val;
        end else begin
          stall_run_left--;
        end
        out_stall <= stall_run_val;
      end
    endcase
  end

  // monitor: check result beats, predict accepted beats
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items pending, %0d results outstanding",
               $time, pending_items.size(), expected_status.size());
      $display("Some tests failed");
      $finish;
    end else begin
      in_fire <= rst_ni && in_valid && !in_stall;
      if (rst_ni && out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no expectation, pack_voltage %0h", $time,
                   pack_voltage_dv);
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          check_field("pack_voltage_dv", want.pack_v, pack_voltage_dv);
          check_field("soc_pptt", want.soc, soc_pptt);
          check_field("health_pptt", want.soh, health_pptt);
          check_field("min_cell_mv", want.min_cell, min_cell_mv);
          check_field("max_cell_mv", want.max_cell, max_cell_mv);
          check_field("min_temp_dc", want.min_temp, min_temp_dc);
          check_field("max_temp_dc", want.max_temp, max_temp_dc);
          check_field("cell_count", want.cell_count, cell_count);
          check_field("bms_state", want.state, bms_state);
          check_field("status_flags", want.flags, status_flags);
          check_field("cell_voltage_mv", want.cell_v, cell_voltage_mv);
          check_field("cell_balancing", want.cell_bal, cell_balancing);
        end
      end
      if (rst_ni && in_valid && !in_stall) begin
        taken.cmd   = cmd;
        taken.id    = frame_id;
        taken.len   = frame_len;
        taken.data  = frame_bytes;
        taken.query = query_cell;
        decode_item(taken, want);
        expected_status.push_back(want);
        if (taken.cmd) reads_sent++;
        else frames_sent++;
        if (!taken.cmd && (taken.id == bcfd_pkg::ID_CELLV || taken.id == bcfd_pkg::ID_BAL))
          store_frames++;
      end
    end
  end

  initial begin
    int n;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_fire = 1'b0;
    cmd = 1'b0;
    frame_id = '0;
    frame_len = '0;
    frame_bytes = '0;
    query_cell = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    results_checked = 0;
    frames_sent = 0;
    reads_sent = 0;
    store_frames = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = STALL_NONE;
    stall_phase_left = 0;
    stall_run_left = 0;
    stall_run_val = 1'b0;
    {pack_raw, soc_raw, soh_raw, lo_cell, hi_cell, lo_temp, hi_temp} = '0;
    contactor_closed = 1'b0;
    cells_seen = '0;
    for (n = 0; n < 4; n++) begin
      alarm_w[n] = '0;
      fault_w[n] = '0;
    end
    for (n = 0; n < bcfd_pkg::CELL_SLOTS; n++) begin
      cell_mv[n] = '0;
      bal_bit[n] = 1'b0;
    end

    pending_items.push_back(cell_read(8'd0));
    pending_items.push_back(cell_read(8'd255));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN, 4'd8, 64'h0000_0000_FFFF_0043));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN, 4'd8, 64'h0000_03E7_FFFF_0083));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN, 4'd15, 64'h0000_03E8_0000_0083));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN, 4'd7, 64'h0000_0000_1234_0043));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN, 4'd8, 64'h0000_0000_5678_0000));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_VOLT, 4'd8, 64'hAAAA_0C80_5555_0043));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_VOLT, 4'd8, 64'h0000_FFFF_0000_0083));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_TEMP, 4'd8, 64'h0000_8000_0000_0043));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_TEMP, 4'd8, 64'h0000_7FFF_0000_0083));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_SWITCH, 4'd15, 64'h0000_0000_0002_0000));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_ALARM, 4'd4, 64'h0000_0000_0001_0000));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_ALARM, 4'd3, 64'h0000_0000_0000_0000));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_FAULT, 4'd15, 64'h3333_2222_1111_FE00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_FAULT, 4'd8, 64'h0000_0000_0000_0000));
    // word for subindex four must be dropped
    pending_items.push_back(mk_frame(bcfd_pkg::ID_FAULT, 4'd7, 64'h0000_BEEF_0000_0300));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_CELLV, 4'd8, 64'h1234_0F00_0E10_BE00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_CELLV, 4'd8, 64'h0C00_0000_0D00_FE00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_CELLV, 4'd8, 64'hFFFF_0000_0001_BD00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_CELLV, 4'd0, 64'hFFFF_FFFF_FFFF_0500));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_BAL, 4'd8, 64'h0100_80FF_0001_BC00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_BAL, 4'd8, 64'h0000_0001_0101_FE00));
    pending_items.push_back(mk_frame(bcfd_pkg::ID_MAIN ^ 29'h1000_0000, 4'd8,
                                     64'hFFFF_FFFF_FFFF_0043));
    pending_items.push_back(cell_read(8'd0));
    pending_items.push_back(cell_read(8'd189));
    pending_items.push_back(cell_read(8'd190));
    pending_items.push_back(cell_read(8'd191));
    for (n = 0; n < RANDOM_ITEMS; n++) pending_items.push_back(random_item());

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);

    if (expected_status.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_status.size());
    $display("Covered %0d frames (%0d cell-store frames) and %0d cell reads;",
             frames_sent, store_frames, reads_sent);
    $display("%0d result beats compared field by field, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
